### design/task_table_fifo_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Task table scheduler assertion macros
// Shared property forms for the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef TASK_TABLE_FIFO_SCHEDULER_DEFINES_SVH
`define TASK_TABLE_FIFO_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tts_pkg.sv
// ----------------------------------------------------------------------------
// Task table scheduler package
// Field widths, request codes and the control/status types of a cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned FUNC_W        = 3;
  localparam int unsigned RSLOT_W       = 4;

  localparam logic [FUNC_W-1:0] FUNC_CREATE   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXIT     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_BLOCK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNBLOCK  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 3'd4;

  // chain commands: append at the tail, remove the first matching entry
  typedef struct packed {
    logic push;
    logic remove;
  } chain_ctl_t;

  typedef struct packed {
    logic any_hit;
    logic full;
    logic empty;
  } chain_sts_t;

endpackage

`default_nettype wire

### design/tts_cell.sv
// ----------------------------------------------------------------------------
// Task table scheduler list cell
// One entry of an ordered list; shifts toward the head on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_cell #(
  parameter int unsigned W = tts_pkg::ID_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tts_pkg::chain_ctl_t ctl,
  input  wire logic [W-1:0]      push_data,
  input  wire logic [W-1:0]      key,
  input  wire logic [W-1:0]      mask,
  input  wire logic              prev_valid,
  input  wire logic              seen_in,
  input  wire logic [W-1:0]      next_data,
  input  wire logic              next_valid,
  output logic [W-1:0]           data,
  output logic                   valid,
  output logic                   seen_out
);
  import tts_pkg::*;

  logic hit;

  assign hit      = valid && (((data ^ key) & mask) == '0);
  assign seen_out = seen_in | hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.remove && seen_out) begin
      // take the neighbor's entry at and after the first match
      valid <= next_valid;
    end else if (ctl.push && prev_valid && !valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.remove && seen_out) begin
      data <= next_data;
    end else if (ctl.push && prev_valid && !valid) begin
      data <= push_data;
    end
  end

endmodule

`default_nettype wire

### design/tts_chain.sv
// ----------------------------------------------------------------------------
// Task table scheduler cell chain
// Ordered list built from a row of cells, with tail append and first-match
// removal.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_chain #(
  parameter int unsigned DEPTH = tts_pkg::NUM_SLOTS_DEF,
  parameter int unsigned W     = tts_pkg::ID_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tts_pkg::chain_ctl_t          ctl,
  input  wire logic [W-1:0]                 push_data,
  input  wire logic [W-1:0]                 key,
  input  wire logic [W-1:0]                 mask,
  output logic [W-1:0]                      head_data,
  output logic [W-1:0]                      hit_data,
  output tts_pkg::chain_sts_t               sts,
  output logic [$clog2(DEPTH+1)-1:0]        count
);
  import tts_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [W-1:0]   cell_data [DEPTH];
  logic [W-1:0]   nxt_data  [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] prev_v;
  logic [DEPTH-1:0] nxt_v;
  logic [DEPTH:0]   seen;

  assign seen[0] = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign prev_v[k] = 1'b1;
    end else begin : g_rest
      assign prev_v[k] = cell_valid[k-1];
    end
    if (k == DEPTH-1) begin : g_last
      assign nxt_data[k] = '0;
      assign nxt_v[k]    = 1'b0;
    end else begin : g_inner
      assign nxt_data[k] = cell_data[k+1];
      assign nxt_v[k]    = cell_valid[k+1];
    end

    tts_cell #(.W(W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .push_data  (push_data),
      .key        (key),
      .mask       (mask),
      .prev_valid (prev_v[k]),
      .seen_in    (seen[k]),
      .next_data  (nxt_data[k]),
      .next_valid (nxt_v[k]),
      .data       (cell_data[k]),
      .valid      (cell_valid[k]),
      .seen_out   (seen[k+1])
    );
  end

  // pick the entry of the first match
  always_comb begin
    hit_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (seen[k+1] && !seen[k]) begin
        hit_data = hit_data | cell_data[k];
      end
    end
  end

  assign head_data   = cell_data[0];
  assign sts.any_hit = seen[DEPTH];
  assign sts.full    = (count == CW'(DEPTH));
  assign sts.empty   = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.remove && sts.any_hit) begin
      count <= count - 1'b1;
    end else if (ctl.push && !sts.full) begin
      count <= count + 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/task_table_fifo_scheduler.sv
// Result path: a request is latched, executed and held until the output register takes it;
//   block and dispatch add an owner id read, exit a blocked-list sweep, create a slot probe walk.
// Throughput: one request at a time; the next is taken once the result sits in
//   the output register, set by the slot probe walk and the blocked-list sweep.
// Reset (synchronous rst): all slots terminated, both lists empty, id counter 1,
//   current slot 0; no clearing pass, owner ids are undefined until written.
// ----------------------------------------------------------------------------
// Task table scheduler
// Slot table with a FIFO ready queue and an ordered blocked list, each list a
// row of shifting cells. One request in, one result out.
// ----------------------------------------------------------------------------
`default_nettype none

module task_table_fifo_scheduler #(
  parameter int unsigned NUM_SLOTS = tts_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tts_pkg::FUNC_W-1:0]    func,
  input  wire logic [tts_pkg::ID_W-1:0]      task_id,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               ok,
  output logic [tts_pkg::ID_W-1:0]           result_id,
  output logic [tts_pkg::RSLOT_W-1:0]        result_slot
);
  import tts_pkg::*;

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS+1);
  localparam int unsigned BW = ID_W + SW;

  // one-hot sequencer
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_PROBE  = 7'b0000100,
    S_SWEEP  = 7'b0001000,
    S_BLK_RD = 7'b0010000,
    S_DSP_RD = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state;

  // request latch
  logic [FUNC_W-1:0] func_q;
  logic [ID_W-1:0]   want_q;

  // scheduler state
  logic [ID_W-1:0]      id_counter;
  logic [SW-1:0]        id_mod;        // id_counter modulo NUM_SLOTS
  logic [SW-1:0]        cur;
  logic [NUM_SLOTS-1:0] slot_busy;     // set: slot not terminated
  logic [ID_W-1:0]      owner_mem [NUM_SLOTS];
  logic [ID_W-1:0]      owner_q;
  logic [SW-1:0]        owner_raddr;
  logic                 owner_we;

  // create probe
  logic [ID_W-1:0] pid_q;
  logic [SW-1:0]   probe_ptr;
  logic [SW-1:0]   probe_cnt;

  // pending result
  logic              res_ok;
  logic [ID_W-1:0]   res_id;
  logic [RSLOT_W-1:0] res_slot;

  // lists
  chain_ctl_t  r_ctl, b_ctl;
  chain_sts_t  r_sts, b_sts;
  logic [SW-1:0] r_push_data, r_head, r_hit_unused;
  logic [CW-1:0] r_count, b_count;
  logic [BW-1:0] b_push_data, b_key, b_mask, b_hit_data, b_head_unused;
  logic [SW-1:0] b_hit_slot;

  logic in_exec, probe_free, unblock_go, out_load;

  assign in_stall   = (state != S_IDLE);
  assign in_exec    = (state == S_EXEC);
  assign probe_free = (state == S_PROBE) && !slot_busy[probe_ptr];
  assign b_hit_slot = b_hit_data[SW-1:0];
  assign unblock_go = in_exec && (func_q == FUNC_UNBLOCK) && b_sts.any_hit && !r_sts.full;
  assign out_load   = (state == S_RESP) && (!out_valid || !out_stall);

  // ready queue: push a probed slot or an unblocked slot, pop the head on dispatch
  always_comb begin
    r_ctl.push   = (probe_free && !r_sts.full) || unblock_go;
    r_ctl.remove = in_exec && (func_q == FUNC_DISPATCH) && !r_sts.empty;
    r_push_data  = (state == S_PROBE) ? probe_ptr : b_hit_slot;
  end

  // blocked list: entries carry the owner id captured at block time
  always_comb begin
    b_ctl.push   = (state == S_BLK_RD);
    b_ctl.remove = (state == S_SWEEP) || unblock_go;
    b_push_data  = {owner_q, cur};
    if (state == S_SWEEP) begin
      b_key  = {{ID_W{1'b0}}, cur};
      b_mask = {{ID_W{1'b0}}, {SW{1'b1}}};
    end else begin
      b_key  = {want_q, {SW{1'b0}}};
      b_mask = {{ID_W{1'b1}}, {SW{1'b0}}};
    end
  end

  tts_chain #(.DEPTH(NUM_SLOTS), .W(SW)) u_ready (
    .clk       (clk),
    .rst       (rst),
    .ctl       (r_ctl),
    .push_data (r_push_data),
    .key       ({SW{1'b0}}),
    .mask      ({SW{1'b0}}),
    .head_data (r_head),
    .hit_data  (r_hit_unused),
    .sts       (r_sts),
    .count     (r_count)
  );

  tts_chain #(.DEPTH(NUM_SLOTS), .W(BW)) u_blocked (
    .clk       (clk),
    .rst       (rst),
    .ctl       (b_ctl),
    .push_data (b_push_data),
    .key       (b_key),
    .mask      (b_mask),
    .head_data (b_head_unused),
    .hit_data  (b_hit_data),
    .sts       (b_sts),
    .count     (b_count)
  );

  // owner id memory: written by create, read for block and dispatch
  assign owner_we    = probe_free && !r_sts.full;
  assign owner_raddr = (func_q == FUNC_DISPATCH) ? r_head : cur;

  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[probe_ptr] <= pid_q;
    end
    owner_q <= owner_mem[owner_raddr];
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      id_counter <= ID_W'(1);
      id_mod     <= SW'(1);
      cur        <= '0;
      slot_busy  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one loads in its place
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            want_q <= task_id;
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          unique case (func_q)
            FUNC_CREATE: begin
              res_ok   <= 1'b0;
              res_id   <= '0;
              res_slot <= '0;
              // table full: no id consumed
              if (({1'b0, r_count} + {1'b0, b_count}) < (CW+1)'(NUM_SLOTS)) begin
                pid_q      <= id_counter;
                id_counter <= id_counter + 1'b1;
                if (id_counter == '1 || id_mod == SW'(NUM_SLOTS-1)) begin
                  id_mod <= '0;
                end else begin
                  id_mod <= id_mod + 1'b1;
                end
                probe_ptr <= id_mod;
                probe_cnt <= '0;
                state     <= S_PROBE;
              end else begin
                state <= S_RESP;
              end
            end
            FUNC_EXIT: begin
              slot_busy[cur] <= 1'b0;
              res_ok         <= 1'b1;
              res_id         <= '0;
              res_slot       <= RSLOT_W'(cur);
              state          <= S_SWEEP;
            end
            FUNC_BLOCK: begin
              res_id <= '0;
              if (!b_sts.full) begin
                slot_busy[cur] <= 1'b1;
                res_ok         <= 1'b1;
                res_slot       <= RSLOT_W'(cur);
                state          <= S_BLK_RD;
              end else begin
                res_ok   <= 1'b0;
                res_slot <= '0;
                state    <= S_RESP;
              end
            end
            FUNC_UNBLOCK: begin
              res_id <= '0;
              state  <= S_RESP;
              if (unblock_go) begin
                slot_busy[b_hit_slot] <= 1'b1;
                res_ok                <= 1'b1;
                res_slot              <= RSLOT_W'(b_hit_slot);
              end else begin
                res_ok   <= 1'b0;
                res_slot <= '0;
              end
            end
            FUNC_DISPATCH: begin
              res_id <= '0;
              if (!r_sts.empty) begin
                cur               <= r_head;
                slot_busy[r_head] <= 1'b1;
                res_ok            <= 1'b1;
                res_slot          <= RSLOT_W'(r_head);
                state             <= S_DSP_RD;
              end else begin
                res_ok   <= 1'b0;
                res_slot <= '0;
                state    <= S_RESP;
              end
            end
            default: begin
              res_ok   <= 1'b0;
              res_id   <= '0;
              res_slot <= '0;
              state    <= S_RESP;
            end
          endcase
        end

        S_PROBE: begin
          // walk one slot a cycle from the id's home slot, wrapping
          if (!slot_busy[probe_ptr]) begin
            if (!r_sts.full) begin
              slot_busy[probe_ptr] <= 1'b1;
              res_ok               <= 1'b1;
              res_id               <= pid_q;
              res_slot             <= RSLOT_W'(probe_ptr);
            end
            state <= S_RESP;
          end else if (probe_cnt == SW'(NUM_SLOTS-1)) begin
            state <= S_RESP;
          end else begin
            probe_ptr <= (probe_ptr == SW'(NUM_SLOTS-1)) ? '0 : probe_ptr + 1'b1;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end

        S_SWEEP: begin
          // remove one occurrence of the exiting slot per cycle until none remain
          if (!b_sts.any_hit) begin
            state <= S_RESP;
          end
        end

        S_BLK_RD: begin
          // owner id arrives this cycle and goes into the blocked list
          state <= S_RESP;
        end

        S_DSP_RD: begin
          res_id <= owner_q;
          state  <= S_RESP;
        end

        S_RESP: begin
          // hold until the output register is free
          if (out_load) begin
            ok          <= res_ok;
            result_id   <= res_id;
            result_slot <= res_slot;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/tts_checker.sv
// ----------------------------------------------------------------------------
// Task table scheduler checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "task_table_fifo_scheduler_defines.svh"

module tts_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        ok,
  input wire logic [tts_pkg::ID_W-1:0]    result_id,
  input wire logic [tts_pkg::RSLOT_W-1:0] result_slot
);
  import tts_pkg::*;

  // a stalled result holds
  `TTS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(ok) && $stable(result_id) && $stable(result_slot), "stalled result changed")

  // a failed request reports neither id nor slot
  `TTS_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !ok, (result_id == '0) && (result_slot == '0), "failed result carries id or slot")

  // one request at a time: busy right after an accept
  `TTS_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall, "request accepted while another is in work")

endmodule

bind task_table_fifo_scheduler tts_checker u_tts_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .ok          (ok),
  .result_id   (result_id),
  .result_slot (result_slot)
);

`default_nettype wire
